FILE: rtl/core/pixel_color_style_mapper_defines.svh
// assertion macros for the pixel colour style mapper checker
// used by pcsm_checker, no other dependencies
`ifndef PIXEL_COLOR_STYLE_MAPPER_DEFINES_SVH
`define PIXEL_COLOR_STYLE_MAPPER_DEFINES_SVH

// implication checked out of reset
`define PCSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is due in the next cycle
`define PCSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// property that also holds while reset is applied
`define PCSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/pcsm_pkg.sv
// shared types, constants and arithmetic helpers of the pixel colour style mapper
// no dependencies
`default_nettype none

package pcsm_pkg;

  localparam int unsigned MaxDarkenDef = 8;

  localparam logic [15:0] LumR = 16'd13926;
  localparam logic [15:0] LumG = 16'd46885;
  localparam logic [15:0] LumB = 16'd4725;
  localparam logic [23:0] LumRound = 24'd32768;
  // 2.56 in q14, rounded up so that exact multiples of 25 do not fall short
  localparam logic [15:0] DesatRecip = 16'd41944;
  localparam logic [8:0] FadeMax = 9'd256;
  localparam logic [6:0] DesatMax = 7'd100;

  typedef enum logic [2:0] {
    REG_STYLE  = 3'd0,
    REG_BACK   = 3'd1,
    REG_MIRROR = 3'd2,
    REG_CLOUD  = 3'd3,
    REG_FADE   = 3'd4,
    REG_DESAT  = 3'd5,
    REG_DARKEN = 3'd6,
    REG_BORDER = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_NEON    = 3'd1,
    MODE_NOBOUND = 3'd2,
    MODE_NEON2   = 3'd3,
    MODE_ILLUS   = 3'd4
  } style_mode_e;

  typedef struct packed {
    logic [4:0]  style;
    logic [23:0] back;
    logic [23:0] mirror;
    logic [23:0] cloud;
    logic [8:0]  fade_w;
    logic [8:0]  desat_w;
    logic [3:0]  steps;
    logic [23:0] border;
  } cfg_t;

  typedef struct packed {
    logic [31:0] col;
    logic [31:0] pol;
    logic        tri_flag;
    logic [23:0] rgb;
  } pix_t;

  // floor(x / 3) for x below 768, by reciprocal 683 / 2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // (a * (256 - w) + b * w + 127) >> 8 with w in 0..256
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] w);
    logic [17:0] s;
    s = 18'(a) * 18'(FadeMax - w) + 18'(b) * 18'(w) + 18'd127;
    return s[15:8];
  endfunction

  function automatic logic [23:0] blend24(input logic [23:0] a, input logic [23:0] b,
                                          input logic [8:0] w);
    return {blend8(a[23:16], b[23:16], w), blend8(a[15:8], b[15:8], w),
            blend8(a[7:0], b[7:0], w)};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pixel_color_style_mapper.sv
// top level of the pixel colour style mapper: config registers and the
// pipeline; depends on pcsm_pkg and the pcsm_* stage modules
//
// usage:
// - input channel: in_valid_i with shape_color_i, outline_in_i, mirror_code_i and
//   triangle_flag_i; an item is taken on a clock edge with in_valid_i high and
//   in_stall_o low
// - output channel: out_valid_o with fill_out_o and outline_out_o; an item is
//   delivered on an edge with out_valid_o high and out_stall_i low
// - config channel: cfg_valid_i, cfg_index_i, cfg_data_i; cfg_ready_o is always
//   high, write only while no item is in flight
// - pipeline stages in order: tint, fade, luminance, desaturation, one stage
//   per halving, and the style stage with the output register
// - throughput is one item per cycle while out_stall_i is low; each stage holds
//   one item and advances whenever the stage after it is empty or moving
// - when the receiver stalls the output holds, the pipeline fills its empty
//   stages and then in_stall_o rises; nothing is dropped or repeated
// - reset empties every stage and loads the register defaults (fade weight 256,
//   all others zero)
`default_nettype none

module pixel_color_style_mapper
  import pcsm_pkg::*;
#(
  parameter int unsigned MAX_DARKEN = MaxDarkenDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] shape_color_i,
  input  wire logic [31:0] outline_in_i,
  input  wire logic [1:0]  mirror_code_i,
  input  wire logic        triangle_flag_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      fill_out_o,
  output logic [31:0]      outline_out_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  cfg_t cfg;
  pix_t front_data, tone_data, dark_data;
  logic front_vld, tone_vld, dark_vld;
  logic front_rdy, tone_rdy, dark_rdy, style_rdy;
  logic in_rdy;

  pcsm_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o (cfg)
  );

  pcsm_front u_front (
    .clk_i, .rst_ni,
    .cfg_i           (cfg),
    .in_valid_i,
    .in_ready_o      (in_rdy),
    .shape_color_i, .outline_in_i, .mirror_code_i, .triangle_flag_i,
    .out_valid_o     (front_vld),
    .out_ready_i     (tone_rdy),
    .out_data_o      (front_data)
  );

  pcsm_tone u_tone (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i  (front_vld),
    .in_ready_o  (tone_rdy),
    .in_data_i   (front_data),
    .out_valid_o (tone_vld),
    .out_ready_i (dark_rdy),
    .out_data_o  (tone_data)
  );

  pcsm_darken #(
    .MAX_DARKEN (MAX_DARKEN)
  ) u_darken (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i  (tone_vld),
    .in_ready_o  (dark_rdy),
    .in_data_i   (tone_data),
    .out_valid_o (dark_vld),
    .out_ready_i (style_rdy),
    .out_data_o  (dark_data)
  );

  pcsm_style u_style (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i  (dark_vld),
    .in_ready_o  (style_rdy),
    .in_data_i   (dark_data),
    .out_valid_o,
    .out_ready_i (!out_stall_i),
    .fill_o      (fill_out_o),
    .outline_o   (outline_out_o)
  );

  assign front_rdy  = in_rdy;
  assign in_stall_o = !front_rdy;

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_cfg.sv
// configuration register file, saturates fade and desaturation inputs and keeps
// the desaturation weight ready; depends on pcsm_pkg
`default_nettype none

module pcsm_cfg
  import pcsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic [6:0]  desat_sat;
  logic [22:0] desat_prod;
  logic [8:0]  fade_raw;

  assign cfg_ready_o = 1'b1;
  assign fade_raw    = cfg_data_i[8:0];
  assign desat_sat   = (cfg_data_i[6:0] > DesatMax) ? DesatMax : cfg_data_i[6:0];
  // floor(256 * level / 100)
  assign desat_prod  = 23'(desat_sat) * 23'(DesatRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      cfg_q.fade_w <= FadeMax;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_STYLE:  cfg_q.style  <= cfg_data_i[4:0];
        REG_BACK:   cfg_q.back   <= cfg_data_i;
        REG_MIRROR: cfg_q.mirror <= cfg_data_i;
        REG_CLOUD:  cfg_q.cloud  <= cfg_data_i;
        REG_FADE:   cfg_q.fade_w <= (fade_raw > FadeMax) ? FadeMax : fade_raw;
        REG_DESAT:  cfg_q.desat_w <= desat_prod[22:14];
        REG_DARKEN: cfg_q.steps  <= cfg_data_i[3:0];
        REG_BORDER: cfg_q.border <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_front.sv
// first two stages: colourblind merge with mirror or cloud tint, then fade
// toward the background; depends on pcsm_pkg
`default_nettype none

module pcsm_front
  import pcsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] shape_color_i,
  input  wire logic [31:0] outline_in_i,
  input  wire logic [1:0]  mirror_code_i,
  input  wire logic        triangle_flag_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output pix_t             out_data_o
);

  pix_t s1_d, s1_q, s2_d, s2_q;
  logic s1_vld_q, s2_vld_q;
  logic s1_rdy, s2_rdy;
  logic [7:0]  merged;
  logic [23:0] tint;
  logic        tint_en;

  // red and green merged for colourblind viewing
  assign merged = div3(10'({shape_color_i[23:16], 1'b0}) + 10'(shape_color_i[31:24]) + 10'd1);

  always_comb begin
    s1_d.col = cfg_i.style[4] ? {merged, merged, shape_color_i[15:0]} : shape_color_i;
    s1_d.pol = outline_in_i;
    s1_d.tri_flag = triangle_flag_i;
    tint_en = mirror_code_i != 2'd0;
    tint = mirror_code_i[0] ? cfg_i.mirror : cfg_i.cloud;
    // blend at one half is a plain per-byte average
    s1_d.rgb = s1_d.col[31:8];
    if (tint_en) begin
      s1_d.rgb[23:16] = 8'((9'(s1_d.col[31:24]) + 9'(tint[23:16])) >> 1);
      s1_d.rgb[15:8]  = 8'((9'(s1_d.col[23:16]) + 9'(tint[15:8])) >> 1);
      s1_d.rgb[7:0]   = 8'((9'(s1_d.col[15:8]) + 9'(tint[7:0])) >> 1);
    end
  end

  always_comb begin
    s2_d = s1_q;
    s2_d.rgb = blend24(cfg_i.back, s1_q.rgb, cfg_i.fade_w);
  end

  assign s1_rdy = !s1_vld_q || s2_rdy;
  assign s2_rdy = !s2_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_q <= in_valid_i;
      if (s2_rdy) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) s1_q <= s1_d;
    if (s2_rdy && s1_vld_q) s2_q <= s2_d;
  end

  assign in_ready_o  = s1_rdy;
  assign out_valid_o = s2_vld_q;
  assign out_data_o  = s2_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_tone.sv
// luminance stage and desaturation blend stage
// depends on pcsm_pkg
`default_nettype none

module pcsm_tone
  import pcsm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire pix_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pix_t      out_data_o
);

  pix_t s3_q, s4_d, s4_q;
  logic [7:0]  lum_q;
  logic [23:0] lum_sum;
  logic s3_vld_q, s4_vld_q;
  logic s3_rdy, s4_rdy;

  // q16 luminance, rounded
  assign lum_sum = 24'(in_data_i.rgb[23:16]) * 24'(LumR)
                 + 24'(in_data_i.rgb[15:8]) * 24'(LumG)
                 + 24'(in_data_i.rgb[7:0]) * 24'(LumB) + LumRound;

  // weight zero leaves the colour unchanged, so no bypass is needed
  always_comb begin
    s4_d = s3_q;
    s4_d.rgb = blend24(s3_q.rgb, {lum_q, lum_q, lum_q}, cfg_i.desat_w);
  end

  assign s3_rdy = !s3_vld_q || s4_rdy;
  assign s4_rdy = !s4_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s3_rdy) s3_vld_q <= in_valid_i;
      if (s4_rdy) s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && in_valid_i) begin
      s3_q  <= in_data_i;
      lum_q <= lum_sum[23:16];
    end
    if (s4_rdy && s3_vld_q) s4_q <= s4_d;
  end

  assign in_ready_o  = s3_rdy;
  assign out_valid_o = s4_vld_q;
  assign out_data_o  = s4_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_darken.sv
// one pipeline stage per halving toward the background colour
// depends on pcsm_pkg
`default_nettype none

module pcsm_darken
  import pcsm_pkg::*;
#(
  parameter int unsigned MAX_DARKEN = MaxDarkenDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire pix_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pix_t      out_data_o
);

  logic vld [MAX_DARKEN+1];
  logic rdy [MAX_DARKEN+1];
  pix_t dat [MAX_DARKEN+1];
  logic [23:0] back_half;

  assign back_half = (cfg_i.back & 24'hFEFEFE) >> 1;
  assign vld[0] = in_valid_i;
  assign dat[0] = in_data_i;
  assign rdy[MAX_DARKEN] = out_ready_i;

  for (genvar i = 0; i < MAX_DARKEN; i++) begin : g_step
    pix_t stg_d, stg_q;
    logic stg_vld_q;

    always_comb begin
      stg_d = dat[i];
      // no carry crosses a byte: each half stays below 128
      if ({1'b0, cfg_i.steps} > 5'(i)) begin
        stg_d.rgb = ((dat[i].rgb & 24'hFEFEFE) >> 1) + back_half;
      end
    end

    assign rdy[i] = !stg_vld_q || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_vld_q <= 1'b0;
      end else if (rdy[i]) begin
        stg_vld_q <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && vld[i]) stg_q <= stg_d;
    end

    assign vld[i+1] = stg_vld_q;
    assign dat[i+1] = stg_q;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld[MAX_DARKEN];
  assign out_data_o  = dat[MAX_DARKEN];

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_style.sv
// style mode selection and the output register
// depends on pcsm_pkg
`default_nettype none

module pcsm_style
  import pcsm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire pix_t  in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [31:0] fill_o,
  output logic [31:0] outline_o
);

  logic [31:0] fill_d, fill_q, outl_d, outl_q;
  logic        vld_q, rdy;
  logic [7:0]  alpha;
  logic [31:0] dark;
  logic        nofill;

  function automatic logic [31:0] to_magenta(input logic [31:0] x);
    logic [7:0] mag, nm, gm;
    logic [8:0] nm_s, gm_s;
    mag  = 8'((9'(x[15:8]) + 9'(x[31:24])) >> 1);
    nm   = (mag > x[23:16]) ? mag : x[23:16];
    gm_s = (9'(mag) + 9'(x[23:16])) >> 1;
    gm   = 8'(gm_s[8:1]);
    nm_s = 9'((10'(nm) + 10'd255) >> 1);
    return {nm_s[7:0], gm, nm_s[7:0], x[7:0]};
  endfunction

  function automatic logic [31:0] to_mono(input logic [31:0] x);
    logic [7:0] c;
    c = div3(10'(x[31:24]) + 10'(x[23:16]) + 10'(x[15:8]) + 10'd1);
    return {c, c, c, x[7:0]};
  endfunction

  assign alpha  = in_data_i.col[7:0];
  assign dark   = {in_data_i.rgb, 8'h00};
  assign nofill = cfg_i.style[3];

  always_comb begin
    fill_d = {in_data_i.rgb, alpha};
    outl_d = in_data_i.pol;
    case (style_mode_e'(cfg_i.style[2:0]))
      MODE_NEON: begin
        fill_d = {in_data_i.pol[31:8], alpha};
        outl_d = {in_data_i.rgb, alpha};
        if (in_data_i.col == 32'h0000_00FF) outl_d = 32'hFFFF_FFFF;
        if (nofill && fill_d == 32'h0000_00FF) fill_d = '0;
      end
      MODE_NOBOUND: begin
        outl_d = '0;
      end
      MODE_NEON2: begin
        // the quarter alpha term may carry into blue
        fill_d = dark + 32'(alpha) + 32'(alpha[7:2]);
        outl_d = {in_data_i.rgb, alpha};
        if (in_data_i.col == 32'h0000_00FF) outl_d = 32'hFFFF_FFFF;
        if (in_data_i.pol != 32'h0000_00FF) outl_d = in_data_i.pol;
        if (nofill && fill_d == 32'h0000_00FF) fill_d = '0;
      end
      MODE_ILLUS: begin
        if (in_data_i.pol != '0 && in_data_i.pol[31:8] != cfg_i.border) begin
          fill_d = to_magenta(in_data_i.col);
          outl_d = 32'h0000_00FF;
        end else begin
          fill_d = to_mono(in_data_i.col);
          outl_d = in_data_i.pol;
        end
        if (fill_d[7:0] != 8'h00) fill_d[7:0] = 8'hFF;
        if (outl_d[7:0] != 8'h00) outl_d[7:0] = 8'hFF;
      end
      default: begin
        outl_d = in_data_i.tri_flag ? '0 : in_data_i.pol;
      end
    endcase
  end

  assign rdy = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      fill_q <= fill_d;
      outl_q <= outl_d;
    end
  end

  assign in_ready_o  = rdy;
  assign out_valid_o = vld_q;
  assign fill_o      = fill_q;
  assign outline_o   = outl_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcsm_checker.sv
// port-level checks of the pixel colour style mapper, bound to the top level
// depends on pixel_color_style_mapper_defines.svh
`default_nettype none
`include "pixel_color_style_mapper_defines.svh"

module pcsm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] fill_out_o,
  input wire logic [31:0] outline_out_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o
);

  // a stalled result holds
  `PCSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(fill_out_o) && $stable(outline_out_o), "output changed under stall")

  // the input only backs up when the whole pipeline is full behind a stalled result
  `PCSM_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o,
    out_valid_o && out_stall_i, "input stalled with room in the pipeline")

  // reset empties the output stage
  `PCSM_ASSERT_ALWAYS(a_reset_empty, clk_i, rst_ni || !out_valid_o,
    "output valid during reset")

  // config writes are never held off
  `PCSM_ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o,
    "config write refused")

endmodule

bind pixel_color_style_mapper pcsm_checker u_pcsm_checker (.*);

`default_nettype wire
